// ----- hw/rtl/nsr_pkg.sv -----
// ----------------------------------------------------------------------------
// nsr_pkg: shared constants for the Newton square root block
// Fixed port widths of the request and result fields and of the tolerance
// register.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int RADICAND_WIDTH = 32;
    localparam int ROOT_WIDTH     = 32;
    localparam int TOL_WIDTH      = 8;

endpackage : nsr_pkg

// ----- hw/rtl/newton_square_root_top.sv -----
// ----------------------------------------------------------------------------
// newton_square_root_top: iterative Newton square root in fixed point
// Returns sqrt(n) with FRAC_BITS fraction bits using a single serial divider.
// ----------------------------------------------------------------------------
// Usage
// A request carries the unsigned radicand and is taken when in_valid is high
// and in_stall is low. Only the low INPUT_WIDTH bits of the radicand are used.
// The block works on one request at a time and holds in_stall high from the
// accepting edge until the result has been moved into the output register.
// Each Newton step replaces x by the truncated mean of x and y and then forms
// y = (n << 2*FRAC_BITS) / x on a restoring divider that resolves one quotient
// bit per cycle over the INPUT_WIDTH + 2*FRAC_BITS dividend bits, after the
// compare/update in S_CHECK. The number of steps depends on the radicand and
// the tolerance (up to about 22 for large inputs). A zero radicand goes
// straight to S_DONE, and a radicand of one leaves S_CHECK without a step.
// The result waits in an output register with out_valid high while out_stall
// is high; a new request is already accepted while it waits. The tolerance
// register is written with cfg_wr_en and cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// An asynchronous low rst_n returns the sequencer to idle, drops out_valid and
// clears the tolerance to zero.
// ----------------------------------------------------------------------------
module newton_square_root_top #(
    parameter int INPUT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [nsr_pkg::TOL_WIDTH-1:0]      cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [nsr_pkg::RADICAND_WIDTH-1:0] radicand,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [nsr_pkg::ROOT_WIDTH-1:0]     root
);
    import nsr_pkg::*;

    // x and y width, wide dividend width and division step counter width.
    localparam int XW = INPUT_WIDTH + FRAC_BITS;
    localparam int DW = INPUT_WIDTH + 2 * FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [TOL_WIDTH-1:0]     tol_reg, tol_next;
    logic [INPUT_WIDTH-1:0]   n_reg, n_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [XW-1:0]            y_reg, y_next;
    logic [XW-1:0]            rem_reg, rem_next;
    logic [XW-1:0]            q_reg, q_next;
    logic [DW-1:0]            div_reg, div_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ROOT_WIDTH-1:0]    root_reg, root_next;

    logic [XW:0]              sum;
    logic [XW-1:0]            diff;
    logic [XW:0]              rem_sh;
    logic [XW:0]              rem_sub;
    logic                     q_bit;
    logic [63:0]              x_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign root      = root_reg;

    always_comb
    begin
        state_next     = state_reg;
        tol_next       = tol_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        root_next      = root_reg;

        sum     = {1'b0, x_reg} + {1'b0, y_reg};
        diff    = x_reg - y_reg;
        rem_sh  = {rem_reg, div_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, x_reg};
        q_bit   = (rem_sh >= {1'b0, x_reg});
        x_ext   = 64'(x_reg);

        if (cfg_wr_en)
        begin
            tol_next = cfg_wr_data;
        end

        // The waiting result leaves when the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = radicand[INPUT_WIDTH-1:0];
                    if (radicand[INPUT_WIDTH-1:0] == '0)
                    begin
                        x_next     = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        x_next     = XW'(radicand[INPUT_WIDTH-1:0]) << FRAC_BITS;
                        y_next     = XW'(1) << FRAC_BITS;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                // Keep iterating while x is above y by more than the tolerance.
                if ((x_reg > y_reg) && (diff > XW'(tol_reg)))
                begin
                    x_next     = sum[XW:1];
                    div_next   = DW'(n_reg) << (2 * FRAC_BITS);
                    rem_next   = '0;
                    q_next     = '0;
                    cnt_next   = CW'(DW);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                // One restoring division step per cycle, divisor is x.
                if (q_bit)
                begin
                    rem_next = rem_sub[XW-1:0];
                end
                else
                begin
                    rem_next = rem_sh[XW-1:0];
                end
                q_next   = {q_reg[XW-2:0], q_bit};
                div_next = div_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    y_next     = {q_reg[XW-2:0], q_bit};
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (x_ext > 64'h0000_0000_FFFF_FFFF)
                    begin
                        root_next = '1;
                    end
                    else
                    begin
                        root_next = x_ext[ROOT_WIDTH-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        div_reg  <= div_next;
        root_reg <= root_next;
    end

    // The divisor is never zero while a division runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (x_reg != '0))
        else $error("division started with a zero divisor");

    // The partial remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < x_reg))
        else $error("partial remainder not below divisor");

    // A running division always has steps left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("division step counter ran out");

    // A zero radicand goes straight to the result stage with a zero root.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (radicand[INPUT_WIDTH-1:0] == '0))
        |=> (state_reg == S_DONE) && (x_reg == '0))
        else $error("zero radicand not finished at once");

endmodule : newton_square_root_top

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for newton_square_root_top
// Requests walk a short table of edge radicands and then several random
// phases, each phase under its own tolerance setting. An in-bench Newton
// iteration predicts every root that the table does not give. Both handshake
// sides idle at random.
module tb;

    import nsr_pkg::*;

    // The block is built with its default parameters, and the predictor
    // follows the same widths.
    localparam int INPUT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Size of each random phase. Six phases give about 450 random requests.
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES  = 6;

    // Cycles to keep watching for stray results once nothing is outstanding.
    localparam int TAIL_CYCLES = 50;

    // One expected root, kept with its radicand so that a mismatch report
    // shows which request went wrong.
    typedef struct {
        logic [RADICAND_WIDTH-1:0] radicand;
        logic [ROOT_WIDTH-1:0]     root;
    } root_entry_t;

    // One row of the directed table. Where known is set, the root is typed
    // in; otherwise it comes from the predictor.
    typedef struct packed {
        logic [RADICAND_WIDTH-1:0] radicand;
        logic                      known;
        logic [ROOT_WIDTH-1:0]     root;
    } edge_row_t;

    localparam int NUM_EDGE_ROWS = 16;

    // Directed rows, all run at the reset tolerance of zero. A zero radicand
    // returns zero at once, and a radicand of one stops before the first step
    // because y already equals x, giving exactly 1.0.
    edge_row_t edge_rows [NUM_EDGE_ROWS] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h0000_0001, 1'b1, 32'h0001_0000},
        '{32'h0000_0002, 1'b0, 32'h0},
        '{32'h0000_0003, 1'b0, 32'h0},
        '{32'h0000_0004, 1'b0, 32'h0},
        '{32'h0000_0010, 1'b0, 32'h0},
        '{32'h0000_00FF, 1'b0, 32'h0},
        '{32'h0000_FFFF, 1'b0, 32'h0},
        '{32'h0001_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h5555_5555, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'hFFFF_FFFE, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b1, 32'h0001_0000}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [TOL_WIDTH-1:0]      cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [RADICAND_WIDTH-1:0] radicand;
    logic                      out_valid;
    logic                      out_stall;
    logic [ROOT_WIDTH-1:0]     root;

    // Bench copy of the tolerance register, updated at every write.
    logic [TOL_WIDTH-1:0] tolerance_shadow = '0;

    // Roots still owed by the block, oldest first.
    root_entry_t pending_roots [$];

    int  mismatch_count = 0;

    // When set, neither side inserts idle cycles.
    bit  no_idle = 1'b0;

    newton_square_root_top #(
        .INPUT_WIDTH (INPUT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .radicand    (radicand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root        (root)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Newton square root in Q(FRAC_BITS): x starts at n, y at 1.0. Each step
    // takes the truncated mean of x and y and divides the radicand, widened
    // by two fraction widths, by the new x. The loop runs while x is above y
    // by more than the tolerance, and the final x saturates to the port.
    function automatic logic [ROOT_WIDTH-1:0] newton_root(
        input logic [RADICAND_WIDTH-1:0] n_in,
        input logic [TOL_WIDTH-1:0]      tol
    );
        logic [63:0]  n;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [127:0] dividend;
        n = 64'(n_in) & ((64'd1 << INPUT_WIDTH) - 64'd1);
        if (n == 64'd0)
            return '0;
        x = n << FRAC_BITS;
        y = 64'd1 << FRAC_BITS;
        dividend = 128'(n) << (2 * FRAC_BITS);
        while (x > y && (x - y) > 64'(tol))
        begin
            x = (x + y) >> 1;
            // A zero x cannot occur for a nonzero radicand; guard anyway.
            y = (x == 64'd0) ? 64'd0 : 64'(dividend / 128'(x));
        end
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[ROOT_WIDTH-1:0];
    endfunction

    // Random radicands lean toward a spread of magnitudes: small values hit
    // the short loops, shifted values sweep the widths, and full-width values
    // give the longest runs.
    function automatic logic [RADICAND_WIDTH-1:0] pick_radicand();
        logic [RADICAND_WIDTH-1:0] value;
        case ($urandom_range(0, 9))
            0, 1:    value = $urandom_range(0, 300);
            2, 3, 4: value = $urandom >> $urandom_range(0, 31);
            default: value = $urandom;
        endcase
        return value;
    endfunction

    // Offer one request after a random gap and hold it until the block takes
    // it. The expected root is recorded at the accepting edge. in_valid is
    // left high on return so that a following request with no gap keeps the
    // line asserted.
    task automatic send_request(
        input logic [RADICAND_WIDTH-1:0] value,
        input logic                      known,
        input logic [ROOT_WIDTH-1:0]     known_root
    );
        int          gap;
        root_entry_t entry;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= value;
        // in_stall read right after the edge is the value the block saw.
        do
            @(posedge clk);
        while (in_stall);
        entry.radicand = value;
        entry.root     = known ? known_root : newton_root(value, tolerance_shadow);
        pending_roots.push_back(entry);
    endtask

    // Stop offering requests and wait until every owed root has come back.
    // Once the queue is empty the block is idle.
    task automatic drain_roots();
        in_valid <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    // Write the tolerance register; only called while the block is idle.
    task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        tolerance_shadow  = value;
    endtask

    // Result side: take a root whenever out_valid is high and out_stall is
    // low, compare it with the oldest expectation, then draw how long to
    // stall before the next one.
    initial
    begin : result_side
        int          hold;
        root_entry_t want;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_roots.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: root %h arrived with no request outstanding",
                                 $realtime, root);
                end
                else
                begin
                    want = pending_roots.pop_front();
                    if (root !== want.root)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: radicand %h expected root %h, got %h",
                                     $realtime, want.radicand, want.root, root);
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, 9);
                if (hold > 0)
                    out_stall <= 1'b1;
            end
            else if (out_stall)
            begin
                hold--;
                if (hold <= 0)
                    out_stall <= 1'b0;
            end
        end
    end

    // Main sequence: reset, the directed table at the reset tolerance, then
    // random phases. Every phase change waits for the block to go idle, so
    // the sender pauses with nothing outstanding several times per run.
    initial
    begin : request_side
        logic [TOL_WIDTH-1:0] phase_tol;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        radicand    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed rows run before any write, so they also show that
        // the tolerance resets to zero.
        foreach (edge_rows[i])
            send_request(edge_rows[i].radicand, edge_rows[i].known, edge_rows[i].root);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_roots();
            // Largest tolerance first, then back to zero so that every bit
            // of the register takes both values; later phases are mixed.
            case (phase)
                0:       phase_tol = 8'hFF;
                1:       phase_tol = 8'h00;
                2:       phase_tol = 8'h01;
                4:       phase_tol = 8'h80;
                default: phase_tol = TOL_WIDTH'($urandom_range(0, 255));
            endcase
            write_tolerance(phase_tol);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Half of the zero-tolerance phase runs with no idling on
                // either side, so back-to-back requests and results occur.
                no_idle = (phase == 1) && (k < PHASE_ITEMS / 2);
                send_request(pick_radicand(), 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        drain_roots();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("newton_square_root_top: match");
        else
            $display("newton_square_root_top: mismatch");
        $finish;
    end

    // Watchdog. A worst-case run covers some 470 requests, each of them up to
    // the longest Newton iteration, with idling, so 40 ms leaves a wide margin.
    initial
    begin : watchdog
        #40_000_000;
        $display("newton_square_root_top: mismatch");
        $finish;
    end

endmodule : tb
